/* hw/rtl/shuffled_lehmer_random_defines.svh */
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_defines.svh
// Assertion macros for the shuffled Lehmer random source.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_RANDOM_DEFINES_SVH
`define SHUFFLED_LEHMER_RANDOM_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SLR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SLR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/slr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg
// Constants and shared types of the shuffled Lehmer random source.
// ----------------------------------------------------------------------------
package slr_pkg;

  // Lehmer generator
  localparam int Mult    = 16807;
  localparam int Modulus = 2147483647;
  localparam int Clamp   = 2147483389;

  // shuffle table; slot select is a shift, so the depth is a power of two
  localparam int TableDepth = 32;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int Ndiv       = 1 + (Modulus - 1) / TableDepth;
  localparam int NdivShift  = $clog2(Ndiv);

  // warm-up walk
  localparam int WarmSteps = TableDepth + 8;
  localparam int CntW      = $clog2(WarmSteps);

  localparam int ProdW = 47;  // 32-bit state times 15-bit multiplier

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WLOAD,
    ST_WMUL,
    ST_WFOLD,
    ST_ISSUE,
    ST_RUN
  } slr_state_e;

  typedef struct packed {
    logic warm_load;  // load warm-up start value, arm step counter
    logic mul;        // multiply state by Mult
    logic warm_fold;  // reduce product, fill table during warm-up
    logic issue;      // read slot of held value, multiply state
    logic finish;     // reduce product, swap table slot, load output
  } slr_cmd_t;

  typedef struct packed {
    logic warm_needed;
    logic cnt_zero;
    logic out_free;
  } slr_sts_t;

endpackage

/* hw/rtl/shuffled_lehmer_random.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_lehmer_random
// Minimal-standard Lehmer generator with a 32-entry Bays-Durham shuffle.
// ----------------------------------------------------------------------------
// Each input beat with request set yields one output beat: a shuffled value
// in 1..2147483389 (tdata) and a flag (tuser) that marks a value clamped to
// that limit; value / 2147483647 is the unit fraction. Normally the accept
// cycle of a request reads the shuffle table slot picked by the held value
// and multiplies the state by 16807; the finishing step then folds the
// product mod 2^31-1, swaps the slot and loads the output register. The
// first request after reset or after a seed write runs the warm-up first:
// a load step, 40 generator steps (multiply, fold) that fill the table,
// then an issue step. The output register lets a new request be accepted
// while the previous beat is still waiting; the finishing cycle stalls until
// that beat is taken. The seed is written through cfg_we_i/cfg_wdata_i and
// restarts the generator (warm-up on the next request); the user must write
// it only while the block is idle, which the block itself does not enforce.
// The table has no reset: the warm-up writes every entry before any read.
// ----------------------------------------------------------------------------
`include "shuffled_lehmer_random_defines.svh"

module shuffled_lehmer_random
  import slr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // seed register
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] request, [7:1] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] sample, [31] zero
  output logic        m_axis_tuser    // [0] saturated
);

  slr_cmd_t    cmd;
  slr_sts_t    sts;
  logic [30:0] sample;

  slr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_request_i(s_axis_tdata[0]),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_sample_o   (sample),
    .out_saturated_o(m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, sample};

  // a result is never loaded over a beat that is still waiting
  `SLR_ASSERT_IMP(a_finish_free, clk_i, rst_ni, cmd.finish,
                  !m_axis_tvalid || m_axis_tready, "result overwrote a pending beat")
  // every finished request presents a beat next cycle
  `SLR_ASSERT_NXT(a_finish_valid, clk_i, rst_ni, cmd.finish,
                  m_axis_tvalid, "finished request produced no beat")
  // an accepted request keeps the block busy in the following cycle
  `SLR_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni,
                  s_axis_tvalid && s_axis_tready && s_axis_tdata[0],
                  !s_axis_tready, "new request taken while one is in flight")

endmodule

/* hw/rtl/slr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slr_ram #(
  parameter int Width = 31,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/slr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_datapath
// Generator state, multiplier and modular fold, shuffle table, output beat.
// ----------------------------------------------------------------------------
module slr_datapath
  import slr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  slr_cmd_t    cmd_i,
  output slr_sts_t    sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] out_sample_o,
  output logic        out_saturated_o
);

  logic signed [32:0] state_q, state_d;
  logic [30:0]        held_q, held_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [ProdW-1:0]   prod_q;
  logic [AddrW-1:0]   slot_q;
  logic [30:0]        sample_q;
  logic               saturated_q;

  logic [31:0]        fold_sum;
  logic [30:0]        fold;
  logic signed [32:0] warm_start;
  logic [30:0]        slot_full;
  logic [AddrW-1:0]   slot;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [30:0]        ram_rdata;
  logic               out_free;

  // x mod (2^31 - 1) = low 31 bits + high bits, one correction
  always_comb begin
    fold_sum = {1'b0, prod_q[30:0]} + 32'(prod_q[ProdW-1:31]);
    if (fold_sum >= 32'(Modulus)) begin
      fold_sum = fold_sum - 32'(Modulus);
    end
    fold = fold_sum[30:0];
  end

  // zero or positive state restarts at 1, negative takes its magnitude
  assign warm_start = state_q[32] ? -state_q : 33'sd1;

  always_comb begin
    slot_full = held_q >> NdivShift;
    if (slot_full > 31'(TableDepth - 1)) begin
      slot = AddrW'(TableDepth - 1);
    end else begin
      slot = slot_full[AddrW-1:0];
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign ram_we    = (cmd_i.warm_fold && (cnt_q < CntW'(TableDepth))) || cmd_i.finish;
  assign ram_waddr = cmd_i.finish ? slot_q : cnt_q[AddrW-1:0];

  slr_ram #(
    .Width(31),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(fold),
    .re_i   (cmd_i.issue),
    .raddr_i(slot),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cfg_we_i) begin
      state_d = 33'(signed'(cfg_wdata_i));
      held_d  = '0;
    end else begin
      if (cmd_i.warm_load) begin
        state_d = warm_start;
        cnt_d   = CntW'(WarmSteps - 1);
      end
      if (cmd_i.warm_fold) begin
        state_d = 33'(fold);
        if (cnt_q == '0) begin
          held_d = fold;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      if (cmd_i.finish) begin
        state_d     = 33'(fold);
        held_d      = ram_rdata;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= -33'sd1;
      held_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul || cmd_i.issue) begin
      prod_q <= ProdW'(state_q[31:0]) * ProdW'(Mult);
    end
    if (cmd_i.issue) begin
      slot_q <= slot;
    end
    if (cmd_i.finish) begin
      if (ram_rdata > 31'(Clamp)) begin
        sample_q    <= 31'(Clamp);
        saturated_q <= 1'b1;
      end else begin
        sample_q    <= ram_rdata;
        saturated_q <= 1'b0;
      end
    end
  end

  assign sts_o.warm_needed = state_q[32] || (state_q == '0) || (held_q == '0);
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.out_free    = out_free;

  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = sample_q;
  assign out_saturated_o = saturated_q;

endmodule

/* hw/rtl/slr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_ctrl
// Sequencer for request handling and the warm-up walk.
// ----------------------------------------------------------------------------
module slr_ctrl
  import slr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_request_i,
  output logic     in_ready_o,
  input  slr_sts_t sts_i,
  output slr_cmd_t cmd_o
);

  slr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // a beat with request clear is taken and dropped
        if (in_valid_i && in_request_i) begin
          if (sts_i.warm_needed) begin
            state_d = ST_WLOAD;
          end else begin
            cmd_o.issue = 1'b1;
            state_d     = ST_RUN;
          end
        end
      end
      ST_WLOAD: begin
        cmd_o.warm_load = 1'b1;
        state_d         = ST_WMUL;
      end
      ST_WMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_WFOLD;
      end
      ST_WFOLD: begin
        cmd_o.warm_fold = 1'b1;
        state_d         = sts_i.cnt_zero ? ST_ISSUE : ST_WMUL;
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        // hold product and read data until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
